// File: design/mbcc_pkg.sv
package mbcc_pkg;

    // Counter width and output field width
    localparam int COUNT_BITS = 32;
    localparam int CNT_W      = COUNT_BITS;
    localparam int OUT_W      = 32;
    localparam int EXT_W      = (CNT_W > OUT_W) ? CNT_W : OUT_W;
    localparam int CFG_W      = 16;

    typedef logic [CNT_W-1:0] t_cnt;

    localparam t_cnt              CNT_MAX       = '1;
    localparam logic [OUT_W-1:0]  OUT_MAX       = '1;
    localparam logic [CFG_W-1:0]  MAX_LINE_INIT = 16'd988;

    // Byte codes
    localparam logic [7:0] ASCII_NUL   = 8'h00;
    localparam logic [7:0] ASCII_TAB   = 8'h09;
    localparam logic [7:0] ASCII_LF    = 8'h0A;
    localparam logic [7:0] ASCII_CR    = 8'h0D;
    localparam logic [7:0] ASCII_SPACE = 8'h20;
    localparam logic [7:0] ASCII_TILDE = 8'h7E;
    localparam logic [7:0] ASCII_DEL   = 8'h7F;
    localparam logic [7:0] ASCII_F     = 8'h46;
    localparam logic [7:0] ASCII_R_LC  = 8'h72;
    localparam logic [7:0] ASCII_O_LC  = 8'h6F;
    localparam logic [7:0] ASCII_M_LC  = 8'h6D;

    // Match positions for "From "
    localparam logic [2:0] FROM_IDLE = 3'd0;
    localparam logic [2:0] FROM_LEN  = 3'd5;

    typedef enum logic [2:0] {
        CLS_BINARY     = 3'd0,
        CLS_8BIT_DATA  = 3'd1,
        CLS_8BIT_TEXT  = 3'd2,
        CLS_7BIT_DATA  = 3'd3,
        CLS_7BIT_TEXT  = 3'd4
    } t_body_class;

    // Per-message summary handed from the statistics stage to the classifier
    typedef struct packed {
        logic valid;
        logic nul_seen;
        logic space;
        logic from_seen;
        t_cnt min_line;
        t_cnt max_line;
        t_cnt byte_cnt;
        t_cnt ctl_cnt;
        t_cnt prt_cnt;
        t_cnt high_cnt;
        t_cnt cr_cnt;
        t_cnt lf_cnt;
        t_cnt crlf_cnt;
    } t_snap;

    function automatic t_cnt sat_inc(t_cnt v);
        return (v == CNT_MAX) ? v : v + t_cnt'(1);
    endfunction

    function automatic logic [OUT_W-1:0] sat_out(t_cnt v);
        logic [EXT_W-1:0] ext;
        ext = EXT_W'(v);
        if (ext > EXT_W'(OUT_MAX)) begin
            return OUT_MAX;
        end
        return ext[OUT_W-1:0];
    endfunction

    function automatic logic is_ws(logic [7:0] c);
        return (c == ASCII_TAB) || (c == ASCII_SPACE);
    endfunction

    // Expected byte at each position of "From "
    function automatic logic [7:0] from_char(logic [2:0] pos);
        logic [7:0] ch;
        case (pos)
            3'd0:    ch = ASCII_F;
            3'd1:    ch = ASCII_R_LC;
            3'd2:    ch = ASCII_O_LC;
            3'd3:    ch = ASCII_M_LC;
            3'd4:    ch = ASCII_SPACE;
            default: ch = ASCII_NUL;
        endcase
        return ch;
    endfunction

endpackage

// File: design/mbcc_ifs.sv
interface mbcc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface mbcc_out_if import mbcc_pkg::*;;
    logic             valid;
    logic             ready;
    logic [2:0]       body_class;
    logic             trailing_space;
    logic             leading_from;
    logic [OUT_W-1:0] shortest_line;
    logic [OUT_W-1:0] longest_line;
    logic [OUT_W-1:0] byte_total;
    logic [OUT_W-1:0] control_total;
    logic [OUT_W-1:0] printable_total;
    logic [OUT_W-1:0] high_bit_total;
    logic [OUT_W-1:0] cr_total;
    logic [OUT_W-1:0] lf_total;
    logic [OUT_W-1:0] crlf_total;

    modport source (
        output valid, output body_class, output trailing_space, output leading_from,
        output shortest_line, output longest_line, output byte_total,
        output control_total, output printable_total, output high_bit_total,
        output cr_total, output lf_total, output crlf_total,
        input  ready
    );
    modport sink (
        input  valid, input body_class, input trailing_space, input leading_from,
        input  shortest_line, input longest_line, input byte_total,
        input  control_total, input printable_total, input high_bit_total,
        input  cr_total, input lf_total, input crlf_total,
        output ready
    );
endinterface

// File: design/mbcc_stats.sv
module mbcc_stats import mbcc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mbcc_in_if.sink     i_in,
    output t_snap       o_snap,
    input  logic        i_snap_ready
);

    // Input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;

    // Per-message state
    logic       r_nul_seen;
    t_cnt       r_ctl, r_cr, r_lf, r_crlf, r_prt, r_high, r_byte;
    t_cnt       r_line, r_min, r_max;
    logic [7:0] r_prev, r_bprev;
    logic [2:0] r_from_pos;
    logic       r_space, r_from_flag;

    logic       n_nul_seen;
    t_cnt       n_ctl, n_cr, n_lf, n_crlf, n_prt, n_high, n_byte;
    t_cnt       n_line, n_min, n_max;
    logic [2:0] n_from_pos;
    logic       n_space, n_from_flag;

    t_cnt       line_inc, len_adj, fin_min, fin_max;
    logic       fin_space;
    logic       is_lf;

    t_snap      r_snap;
    logic       snap_free;
    logic       consume;
    logic       snap_load;

    // Handshake: non-final bytes always retire; the final one needs a free snapshot slot
    assign snap_free  = !r_snap.valid || i_snap_ready;
    assign consume    = r_in_valid && (!r_in_last || snap_free);
    assign snap_load  = consume && r_in_last;
    assign i_in.ready = !r_in_valid || consume;
    assign o_snap     = r_snap;

    // Capture the incoming item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
        if (i_in.ready && i_in.valid) begin
            r_in_byte <= i_in.data_byte;
            r_in_last <= i_in.last_byte;
        end
    end

    // Update counts, line lengths and flags for one byte
    always_comb begin
        is_lf       = (r_in_byte == ASCII_LF);
        line_inc    = sat_inc(r_line);
        n_byte      = sat_inc(r_byte);
        n_nul_seen  = r_nul_seen;
        n_ctl       = r_ctl;
        n_cr        = r_cr;
        n_lf        = r_lf;
        n_crlf      = r_crlf;
        n_prt       = r_prt;
        n_high      = r_high;
        n_min       = r_min;
        n_max       = r_max;
        n_space     = r_space;
        n_from_flag = r_from_flag;
        len_adj     = r_line;

        // Match "From " at the start of a line
        if (r_from_pos != FROM_IDLE && r_from_pos < FROM_LEN
            && r_in_byte == from_char(r_from_pos)) begin
            if (r_from_pos == FROM_LEN - 3'd1) begin
                n_from_flag = 1'b1;
                n_from_pos  = FROM_IDLE;
            end else begin
                n_from_pos = r_from_pos + 3'd1;
            end
        end else if (r_in_byte == ASCII_F && r_prev == ASCII_LF) begin
            n_from_pos = 3'd1;
        end else begin
            n_from_pos = FROM_IDLE;
        end

        if (is_lf) begin
            n_lf = sat_inc(r_lf);
            if (r_prev == ASCII_CR) begin
                n_crlf = sat_inc(r_crlf);
                if (r_line != '0) begin
                    len_adj = r_line - t_cnt'(1);
                end
            end
            n_min = (len_adj < r_min) ? len_adj : r_min;
            n_max = (len_adj > r_max) ? len_adj : r_max;
            if (is_ws(r_prev) || (r_prev == ASCII_CR && is_ws(r_bprev))) begin
                n_space = 1'b1;
            end
            n_line = '0;
        end else begin
            n_line = line_inc;
            if (r_in_byte == ASCII_NUL) begin
                n_nul_seen = 1'b1;
            end else if (r_in_byte == ASCII_CR) begin
                n_cr = sat_inc(r_cr);
            end else if (r_in_byte == ASCII_TAB
                         || (r_in_byte >= ASCII_SPACE && r_in_byte <= ASCII_TILDE)) begin
                n_prt = sat_inc(r_prt);
            end else if (r_in_byte == ASCII_DEL || r_in_byte < ASCII_SPACE) begin
                n_ctl = sat_inc(r_ctl);
            end else begin
                n_high = sat_inc(r_high);
            end
        end

        // Fold in the final line: after an LF it is empty
        if (is_lf) begin
            fin_min = '0;
            fin_max = n_max;
        end else begin
            fin_min = (line_inc < r_min) ? line_inc : r_min;
            fin_max = (line_inc > r_max) ? line_inc : r_max;
        end
        fin_space = n_space || is_ws(r_in_byte);
    end

    // Advance state; clear it after the final byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || snap_load) begin
            r_nul_seen  <= 1'b0;
            r_ctl       <= '0;
            r_cr        <= '0;
            r_lf        <= '0;
            r_crlf      <= '0;
            r_prt       <= '0;
            r_high      <= '0;
            r_byte      <= '0;
            r_line      <= '0;
            r_min       <= CNT_MAX;
            r_max       <= '0;
            r_prev      <= ASCII_LF;
            r_bprev     <= ASCII_NUL;
            r_from_pos  <= FROM_IDLE;
            r_space     <= 1'b0;
            r_from_flag <= 1'b0;
        end else if (consume) begin
            r_nul_seen  <= n_nul_seen;
            r_ctl       <= n_ctl;
            r_cr        <= n_cr;
            r_lf        <= n_lf;
            r_crlf      <= n_crlf;
            r_prt       <= n_prt;
            r_high      <= n_high;
            r_byte      <= n_byte;
            r_line      <= n_line;
            r_min       <= n_min;
            r_max       <= n_max;
            r_prev      <= r_in_byte;
            r_bprev     <= r_prev;
            r_from_pos  <= n_from_pos;
            r_space     <= n_space;
            r_from_flag <= n_from_flag;
        end
    end

    // Hold the message summary until the classifier takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_snap.valid <= 1'b0;
        end else if (snap_load) begin
            r_snap.valid <= 1'b1;
        end else if (i_snap_ready) begin
            r_snap.valid <= 1'b0;
        end
        if (snap_load) begin
            r_snap.nul_seen  <= n_nul_seen;
            r_snap.space     <= fin_space;
            r_snap.from_seen <= n_from_flag;
            r_snap.min_line  <= fin_min;
            r_snap.max_line  <= fin_max;
            r_snap.byte_cnt  <= n_byte;
            r_snap.ctl_cnt   <= n_ctl;
            r_snap.prt_cnt   <= n_prt;
            r_snap.high_cnt  <= n_high;
            r_snap.cr_cnt    <= n_cr;
            r_snap.lf_cnt    <= n_lf;
            r_snap.crlf_cnt  <= n_crlf;
        end
    end

    a_from_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_from_pos < FROM_LEN)
        else $error("from matcher position out of range");

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        snap_load |=> (r_byte == '0 && r_line == '0 && r_prev == ASCII_LF))
        else $error("message state not cleared after final byte");

    a_snap_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_snap.valid && !i_snap_ready) |=> (r_snap.valid && $stable(r_snap.byte_cnt)))
        else $error("pending summary lost or changed");

endmodule

// File: design/mbcc_classify.sv
module mbcc_classify import mbcc_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr_en,
    input  logic [CFG_W-1:0] i_cfg_wr_data,
    input  t_snap            i_snap,
    output logic             o_snap_ready,
    mbcc_out_if.source       o_out
);

    logic [CFG_W-1:0] r_max_line_len;
    logic [CNT_W+2:0] ctl_x5;
    logic             is_data;
    t_body_class      cls;

    logic             r_out_valid;
    t_body_class      r_class;
    logic             r_space, r_from;
    logic [OUT_W-1:0] r_min, r_max, r_byte, r_ctl, r_prt, r_high, r_cr, r_lf, r_crlf;

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_line_len <= MAX_LINE_INIT;
        end else if (i_cfg_wr_en) begin
            r_max_line_len <= i_cfg_wr_data;
        end
    end

    // Decide the class; control share test is 5*ctl > total
    always_comb begin
        ctl_x5  = (CNT_W+3)'({i_snap.ctl_cnt, 2'b00}) + (CNT_W+3)'(i_snap.ctl_cnt);
        is_data = (i_snap.max_line > t_cnt'(r_max_line_len))
               || (i_snap.cr_cnt != i_snap.crlf_cnt)
               || (ctl_x5 > (CNT_W+3)'(i_snap.byte_cnt));
        if (i_snap.nul_seen) begin
            cls = CLS_BINARY;
        end else if (i_snap.high_cnt != '0) begin
            cls = is_data ? CLS_8BIT_DATA : CLS_8BIT_TEXT;
        end else begin
            cls = is_data ? CLS_7BIT_DATA : CLS_7BIT_TEXT;
        end
    end

    assign o_snap_ready = !r_out_valid || o_out.ready;

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_snap_ready) begin
            r_out_valid <= i_snap.valid;
        end
        if (o_snap_ready && i_snap.valid) begin
            r_class <= cls;
            r_space <= i_snap.space;
            r_from  <= i_snap.from_seen;
            r_min   <= sat_out(i_snap.min_line);
            r_max   <= sat_out(i_snap.max_line);
            r_byte  <= sat_out(i_snap.byte_cnt);
            r_ctl   <= sat_out(i_snap.ctl_cnt);
            r_prt   <= sat_out(i_snap.prt_cnt);
            r_high  <= sat_out(i_snap.high_cnt);
            r_cr    <= sat_out(i_snap.cr_cnt);
            r_lf    <= sat_out(i_snap.lf_cnt);
            r_crlf  <= sat_out(i_snap.crlf_cnt);
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.body_class      = r_class;
    assign o_out.trailing_space  = r_space;
    assign o_out.leading_from    = r_from;
    assign o_out.shortest_line   = r_min;
    assign o_out.longest_line    = r_max;
    assign o_out.byte_total      = r_byte;
    assign o_out.control_total   = r_ctl;
    assign o_out.printable_total = r_prt;
    assign o_out.high_bit_total  = r_high;
    assign o_out.cr_total        = r_cr;
    assign o_out.lf_total        = r_lf;
    assign o_out.crlf_total      = r_crlf;

    a_binary_on_nul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_snap_ready && i_snap.valid && i_snap.nul_seen) |=> (r_class == CLS_BINARY))
        else $error("NUL byte did not give binary class");

    a_7bit_no_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_class == CLS_7BIT_DATA || r_class == CLS_7BIT_TEXT))
        |-> (r_high == '0))
        else $error("7-bit class with 8-bit bytes counted");

    a_out_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_out.ready) |=> (r_out_valid && $stable(r_byte)))
        else $error("pending result lost or changed");

endmodule

// File: design/mail_body_charset_classifier_top.sv
// A final byte passes the input, summary and result registers in turn.
// Throughput: one byte per cycle; a final byte waits while a summary is still held.
// A result waits in the output register while bytes of the next message keep flowing.
// Reset (i_rst_n, synchronous, active low) clears all counts and flags and sets
// max_line_length to 988; no clearing pass is needed.
module mail_body_charset_classifier_top import mbcc_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    mbcc_in_if.sink          i_in,
    mbcc_out_if.source       o_out,
    input  logic             i_cfg_wr_en,
    input  logic [CFG_W-1:0] i_cfg_wr_data
);

    t_snap snap;
    logic  snap_ready;

    // Count and track each byte
    mbcc_stats u_stats (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .o_snap       (snap),
        .i_snap_ready (snap_ready)
    );

    // Classify finished messages
    mbcc_classify u_classify (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_snap        (snap),
        .o_snap_ready  (snap_ready),
        .o_out         (o_out)
    );

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import mbcc_pkg::*;

    localparam int ITEMS_PER_PHASE = 200;
    localparam int WATCHDOG_LIMIT  = 5000;
    localparam int HOLD_CYCLES     = 400;
    localparam int CFG_SETTLE      = 4;
    localparam int END_SETTLE      = 10;
    localparam int LONG_LINE       = 989;

    // "From " packed low byte first
    localparam logic [39:0] FROM_WORD = {ASCII_SPACE, ASCII_M_LC, ASCII_O_LC, ASCII_R_LC, ASCII_F};

    typedef struct packed {
        t_body_class      cls;
        logic             trailing_space;
        logic             leading_from;
        logic [OUT_W-1:0] shortest;
        logic [OUT_W-1:0] longest;
        logic [OUT_W-1:0] total;
        logic [OUT_W-1:0] control;
        logic [OUT_W-1:0] printable;
        logic [OUT_W-1:0] high_bit;
        logic [OUT_W-1:0] cr;
        logic [OUT_W-1:0] lf;
        logic [OUT_W-1:0] crlf;
    } t_body_summary;

    typedef struct packed {
        logic [7:0]    data;
        logic          last;
        logic          typed;
        t_body_summary want;
    } t_stim_row;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             cfg_wr_en;
    logic [CFG_W-1:0] cfg_wr_data;
    logic             sink_ready;

    mbcc_in_if  in_bus();
    mbcc_out_if out_bus();

    assign out_bus.ready = sink_ready;

    mail_body_charset_classifier_top DUT (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in          (in_bus),
        .o_out         (out_bus),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data)
    );

    // Per-message statistics of the predictor
    t_cnt             nul_n, ctl_n, cr_n, lf_n, crlf_n, prt_n, high_n, byte_n;
    t_cnt             line_len, line_min, line_max;
    logic [7:0]       prev_b, prev2_b;
    logic [2:0]       from_pos;
    logic             ws_seen, from_seen;
    logic [CFG_W-1:0] line_limit;

    t_body_summary    pending_summaries[$];
    t_body_summary    front;
    t_stim_row        dir_rows[$];
    logic [7:0]       msg_bytes[$];
    int               mismatches = 0;
    int               src_idle_pct = 0;
    int               stall_pct = 0;
    logic             hold_go = 1'b0;
    logic             hold_done = 1'b0;
    int               hold_left = 0;
    int               quiet_cycles = 0;

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic t_cnt cnt_bump(t_cnt v);
        return (v == '1) ? v : v + t_cnt'(1);
    endfunction

    function automatic logic [OUT_W-1:0] clip_out(t_cnt v);
        logic [63:0] wide;
        wide = 64'(v);
        return (wide > 64'(OUT_MAX)) ? OUT_MAX : wide[OUT_W-1:0];
    endfunction

    function automatic bit is_blank(logic [7:0] c);
        return (c == ASCII_TAB) || (c == ASCII_SPACE);
    endfunction

    function automatic void line_note(t_cnt len);
        if (len > line_max) line_max = len;
        if (len < line_min) line_min = len;
    endfunction

    function automatic void msg_clear();
        nul_n = '0; ctl_n = '0; cr_n = '0; lf_n = '0; crlf_n = '0;
        prt_n = '0; high_n = '0; byte_n = '0;
        line_len = '0; line_min = '1; line_max = '0;
        prev_b = ASCII_LF; prev2_b = ASCII_NUL;
        from_pos = FROM_IDLE; ws_seen = 1'b0; from_seen = 1'b0;
    endfunction

    // Advance the statistics by one byte; on the final byte return the summary
    function automatic bit classify_byte(input logic [7:0] c, input logic last,
                                         output t_body_summary res);
        t_cnt len;
        bit   is_data;
        res = '0;
        byte_n = cnt_bump(byte_n);

        // track "From " at the start of a line
        if (from_pos != FROM_IDLE && from_pos < FROM_LEN && c == FROM_WORD[from_pos*8 +: 8]) begin
            from_pos = from_pos + 3'd1;
            if (from_pos == FROM_LEN) begin
                from_seen = 1'b1;
                from_pos  = FROM_IDLE;
            end
        end else if (c == ASCII_F && prev_b == ASCII_LF) begin
            from_pos = 3'd1;
        end else begin
            from_pos = FROM_IDLE;
        end

        if (c == ASCII_LF) begin
            len  = line_len;
            lf_n = cnt_bump(lf_n);
            if (prev_b == ASCII_CR) begin
                crlf_n = cnt_bump(crlf_n);
                if (len != '0) len = len - t_cnt'(1);
            end
            line_note(len);
            if (is_blank(prev_b) || (prev_b == ASCII_CR && is_blank(prev2_b))) ws_seen = 1'b1;
            line_len = '0;
        end else begin
            line_len = cnt_bump(line_len);
            if (c == ASCII_NUL) nul_n = cnt_bump(nul_n);
            else if (c == ASCII_CR) cr_n = cnt_bump(cr_n);
            else if (c == ASCII_TAB || (c >= ASCII_SPACE && c <= ASCII_TILDE))
                prt_n = cnt_bump(prt_n);
            else if (c == ASCII_DEL || c < ASCII_SPACE) ctl_n = cnt_bump(ctl_n);
            else high_n = cnt_bump(high_n);
        end

        prev2_b = prev_b;
        prev_b  = c;
        if (!last) return 1'b0;

        // close the final line and classify
        line_note(line_len);
        if (is_blank(c)) ws_seen = 1'b1;
        is_data = (line_max > t_cnt'(line_limit)) || (cr_n != crlf_n)
                  || (ctl_n > byte_n / t_cnt'(5));
        if (nul_n != '0) res.cls = CLS_BINARY;
        else if (high_n != '0) res.cls = is_data ? CLS_8BIT_DATA : CLS_8BIT_TEXT;
        else res.cls = is_data ? CLS_7BIT_DATA : CLS_7BIT_TEXT;
        res.trailing_space = ws_seen;
        res.leading_from   = from_seen;
        res.shortest       = clip_out(line_min);
        res.longest        = clip_out(line_max);
        res.total          = clip_out(byte_n);
        res.control        = clip_out(ctl_n);
        res.printable      = clip_out(prt_n);
        res.high_bit       = clip_out(high_n);
        res.cr             = clip_out(cr_n);
        res.lf             = clip_out(lf_n);
        res.crlf           = clip_out(crlf_n);
        msg_clear();
        return 1'b1;
    endfunction

    // Build one random message body into msg_bytes
    function automatic void build_message(bit long_line);
        int         n_lines;
        int         len;
        int         r;
        logic [7:0] c;
        msg_bytes.delete();
        if ($urandom_range(0, 5) == 0) begin
            // raw noise
            len = $urandom_range(1, 30);
            repeat (len) msg_bytes.push_back(8'($urandom_range(0, 255)));
        end else begin
            n_lines = $urandom_range(1, 4);
            for (int k = 0; k < n_lines; k++) begin
                r = $urandom_range(0, 9);
                if (r < 2) begin
                    for (int j = 0; j < 5; j++) msg_bytes.push_back(FROM_WORD[j*8 +: 8]);
                end else if (r == 2) begin
                    msg_bytes.push_back(ASCII_F);
                    msg_bytes.push_back(ASCII_R_LC);
                end
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 90) : $urandom_range(0, 16);
                repeat (len) begin
                    r = $urandom_range(0, 199);
                    if (r == 0) c = 8'($urandom_range(0, 255));
                    else if (r < 4) c = 8'($urandom_range(8'h80, 8'hFF));
                    else if (r < 8) c = ASCII_TAB;
                    else c = 8'($urandom_range(ASCII_SPACE, ASCII_TILDE));
                    msg_bytes.push_back(c);
                end
                if ($urandom_range(0, 5) == 0)
                    msg_bytes.push_back($urandom_range(0, 1) ? ASCII_SPACE : ASCII_TAB);
                // terminate with LF, CRLF or a lone CR; the last line may stay open
                if (!(k == n_lines - 1 && $urandom_range(0, 2) == 0)) begin
                    r = $urandom_range(0, 9);
                    if (r < 9 && r >= 6) msg_bytes.push_back(ASCII_CR);
                    if (r == 9) msg_bytes.push_back(ASCII_CR);
                    else msg_bytes.push_back(ASCII_LF);
                end
            end
        end
        if (long_line) begin
            repeat (LONG_LINE) msg_bytes.push_back(8'($urandom_range(8'h61, 8'h7A)));
            msg_bytes.push_back(ASCII_LF);
        end
        if (msg_bytes.size() == 0) msg_bytes.push_back(8'h61);
    endfunction

    function automatic void check_field(string name, logic [OUT_W-1:0] want,
                                        logic [OUT_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    task automatic add_row(input logic [7:0] c, input logic last, input logic typed,
                           input t_body_summary want);
        t_stim_row row;
        row.data  = c;
        row.last  = last;
        row.typed = typed;
        row.want  = want;
        dir_rows.push_back(row);
    endtask

    // Offer one item, hold it until accepted, then record the expected summary
    task automatic offer_byte(input logic [7:0] c, input logic last, input logic typed,
                              input t_body_summary want);
        t_body_summary predicted;
        while ($urandom_range(0, 99) < src_idle_pct) begin
            in_bus.valid <= 1'b0;
            @(posedge clk);
        end
        in_bus.valid     <= 1'b1;
        in_bus.data_byte <= c;
        in_bus.last_byte <= last;
        @(posedge clk);
        while (!in_bus.ready) @(posedge clk);
        if (classify_byte(c, last, predicted))
            pending_summaries.push_back(typed ? want : predicted);
    endtask

    // Drain, let the pipeline settle, then write the line-length limit
    task automatic write_limit(input logic [CFG_W-1:0] value);
        while (pending_summaries.size() != 0) @(posedge clk);
        repeat (CFG_SETTLE) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        line_limit  = value;
    endtask

    task automatic run_phase(input logic [CFG_W-1:0] limit, input int src_pct,
                             input int sink_pct, input bit pressure, input bit long_line);
        int count;
        write_limit(limit);
        src_idle_pct = src_pct;
        stall_pct   <= sink_pct;
        if (pressure) hold_go <= 1'b1;
        count = 0;
        while (count < ITEMS_PER_PHASE) begin
            build_message(long_line && count == 0);
            foreach (msg_bytes[i])
                offer_byte(msg_bytes[i], i == msg_bytes.size() - 1, 1'b0, '0);
            count += msg_bytes.size();
        end
        in_bus.valid <= 1'b0;
    endtask

    // Receiver: one long hold-off on request, otherwise random stalls
    always @(posedge clk) begin
        if (hold_left != 0) begin
            sink_ready <= 1'b0;
            hold_left  <= hold_left - 1;
        end else if (hold_go && !hold_done) begin
            sink_ready <= 1'b0;
            hold_left  <= HOLD_CYCLES;
            hold_done  <= 1'b1;
        end else begin
            sink_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // Compare each accepted summary with the oldest expectation
    always @(posedge clk) begin
        if (rst_n && out_bus.valid && out_bus.ready) begin
            if (pending_summaries.size() == 0) begin
                $display("%0t: unexpected result, expected none actual class %0d",
                         $time, out_bus.body_class);
                mismatches++;
            end else begin
                front = pending_summaries.pop_front();
                check_field("body_class", 32'(front.cls), 32'(out_bus.body_class));
                check_field("trailing_space", 32'(front.trailing_space),
                            32'(out_bus.trailing_space));
                check_field("leading_from", 32'(front.leading_from), 32'(out_bus.leading_from));
                check_field("shortest_line", front.shortest, out_bus.shortest_line);
                check_field("longest_line", front.longest, out_bus.longest_line);
                check_field("byte_total", front.total, out_bus.byte_total);
                check_field("control_total", front.control, out_bus.control_total);
                check_field("printable_total", front.printable, out_bus.printable_total);
                check_field("high_bit_total", front.high_bit, out_bus.high_bit_total);
                check_field("cr_total", front.cr, out_bus.cr_total);
                check_field("lf_total", front.lf, out_bus.lf_total);
                check_field("crlf_total", front.crlf, out_bus.crlf_total);
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge clk) begin
        if (!rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no item moved for %0d cycles", $time, quiet_cycles);
            $display("FAIL mail_body_charset_classifier_top");
            $finish;
        end
    end

    initial begin
        in_bus.valid     <= 1'b0;
        in_bus.data_byte <= 8'h00;
        in_bus.last_byte <= 1'b0;
        cfg_wr_en        <= 1'b0;
        cfg_wr_data      <= '0;
        sink_ready       <= 1'b0;
        rst_n            <= 1'b0;
        msg_clear();
        line_limit = MAX_LINE_INIT;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // one-byte messages of every byte class, with their summaries written out
        add_row(8'h41, 1'b1, 1'b1, t_body_summary'{CLS_7BIT_TEXT, 1'b0, 1'b0,
                32'd1, 32'd1, 32'd1, 32'd0, 32'd1, 32'd0, 32'd0, 32'd0, 32'd0});
        add_row(ASCII_NUL, 1'b1, 1'b1, t_body_summary'{CLS_BINARY, 1'b0, 1'b0,
                32'd1, 32'd1, 32'd1, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0});
        add_row(8'h80, 1'b1, 1'b1, t_body_summary'{CLS_8BIT_TEXT, 1'b0, 1'b0,
                32'd1, 32'd1, 32'd1, 32'd0, 32'd0, 32'd1, 32'd0, 32'd0, 32'd0});
        add_row(8'hFF, 1'b1, 1'b1, t_body_summary'{CLS_8BIT_TEXT, 1'b0, 1'b0,
                32'd1, 32'd1, 32'd1, 32'd0, 32'd0, 32'd1, 32'd0, 32'd0, 32'd0});
        add_row(8'h01, 1'b1, 1'b1, t_body_summary'{CLS_7BIT_DATA, 1'b0, 1'b0,
                32'd1, 32'd1, 32'd1, 32'd1, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0});
        add_row(ASCII_DEL, 1'b1, 1'b1, t_body_summary'{CLS_7BIT_DATA, 1'b0, 1'b0,
                32'd1, 32'd1, 32'd1, 32'd1, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0});
        add_row(ASCII_LF, 1'b1, 1'b1, t_body_summary'{CLS_7BIT_TEXT, 1'b0, 1'b0,
                32'd0, 32'd0, 32'd1, 32'd0, 32'd0, 32'd0, 32'd0, 32'd1, 32'd0});
        add_row(ASCII_CR, 1'b1, 1'b1, t_body_summary'{CLS_7BIT_DATA, 1'b0, 1'b0,
                32'd1, 32'd1, 32'd1, 32'd0, 32'd0, 32'd0, 32'd1, 32'd0, 32'd0});
        add_row(ASCII_SPACE, 1'b1, 1'b1, t_body_summary'{CLS_7BIT_TEXT, 1'b1, 1'b0,
                32'd1, 32'd1, 32'd1, 32'd0, 32'd1, 32'd0, 32'd0, 32'd0, 32'd0});
        add_row(ASCII_TAB, 1'b1, 1'b1, t_body_summary'{CLS_7BIT_TEXT, 1'b1, 1'b0,
                32'd1, 32'd1, 32'd1, 32'd0, 32'd1, 32'd0, 32'd0, 32'd0, 32'd0});
        add_row(ASCII_TILDE, 1'b1, 1'b1, t_body_summary'{CLS_7BIT_TEXT, 1'b0, 1'b0,
                32'd1, 32'd1, 32'd1, 32'd0, 32'd1, 32'd0, 32'd0, 32'd0, 32'd0});
        // "From " then CRLF: leading match, blank before the CRLF
        for (int j = 0; j < 5; j++) add_row(FROM_WORD[j*8 +: 8], 1'b0, 1'b0, '0);
        add_row(ASCII_CR, 1'b0, 1'b0, '0);
        add_row(ASCII_LF, 1'b1, 1'b0, '0);
        // partial match cut by the end of the message
        add_row(ASCII_F, 1'b0, 1'b0, '0);
        add_row(ASCII_R_LC, 1'b1, 1'b0, '0);
        // lone CR inside a line, then a plain LF
        add_row(8'h61, 1'b0, 1'b0, '0);
        add_row(ASCII_CR, 1'b0, 1'b0, '0);
        add_row(8'h62, 1'b0, 1'b0, '0);
        add_row(ASCII_LF, 1'b1, 1'b0, '0);

        foreach (dir_rows[i])
            offer_byte(dir_rows[i].data, dir_rows[i].last, dir_rows[i].typed, dir_rows[i].want);
        in_bus.valid <= 1'b0;

        // random phases over limits and idle patterns
        run_phase(MAX_LINE_INIT, 0, 0, 1'b0, 1'b1);
        run_phase(16'd0, 63, 0, 1'b0, 1'b0);
        run_phase(16'hFFFF, 0, 63, 1'b0, 1'b0);
        run_phase(16'($urandom_range(1, 60)), 37, 37, 1'b0, 1'b0);
        run_phase(16'($urandom_range(20, 120)), 0, 0, 1'b1, 1'b0);
        run_phase(16'($urandom_range(4, 30)), 63, 63, 1'b0, 1'b0);

        while (pending_summaries.size() != 0) @(posedge clk);
        repeat (END_SETTLE) @(posedge clk);
        if (mismatches == 0) begin
            $display("PASS mail_body_charset_classifier_top");
        end else begin
            $display("FAIL mail_body_charset_classifier_top");
        end
        $finish;
    end

endmodule
